// ===== rtl/ringtone_text_note_parser_defines.svh =====
// Assertion macros shared by the ringtone parser RTL.
`ifndef RINGTONE_TEXT_NOTE_PARSER_DEFINES_SVH
`define RINGTONE_TEXT_NOTE_PARSER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RTP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtp assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtp assertion failed");

`endif

// ===== rtl/rtp_pkg.sv =====
// Shared constants, types and the frequency table of the ringtone parser.
package rtp_pkg;

  localparam int NUMBER_LIMIT = 9999;
  localparam int NUM_W = 14;
  localparam int WHOLE_W = 18;
  localparam int TIME_W = 20;
  localparam int FREQ_W = 15;
  localparam int DIV_STEPS = WHOLE_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [FREQ_W-1:0] FREQ_TAB [0:12][0:9] = '{
    '{15'd16, 15'd32, 15'd65, 15'd130, 15'd261, 15'd523, 15'd1046, 15'd2093, 15'd4186,
      15'd8372},
    '{15'd17, 15'd34, 15'd69, 15'd138, 15'd277, 15'd554, 15'd1108, 15'd2217, 15'd4434,
      15'd8869},
    '{15'd18, 15'd36, 15'd73, 15'd146, 15'd293, 15'd587, 15'd1174, 15'd2349, 15'd4698,
      15'd9397},
    '{15'd19, 15'd38, 15'd77, 15'd155, 15'd311, 15'd622, 15'd1244, 15'd2489, 15'd4978,
      15'd9956},
    '{15'd20, 15'd41, 15'd82, 15'd164, 15'd329, 15'd659, 15'd1318, 15'd2637, 15'd5274,
      15'd10548},
    '{15'd21, 15'd43, 15'd87, 15'd174, 15'd349, 15'd698, 15'd1396, 15'd2793, 15'd5587,
      15'd11175},
    '{15'd23, 15'd46, 15'd92, 15'd185, 15'd370, 15'd740, 15'd1480, 15'd2960, 15'd5920,
      15'd11840},
    '{15'd24, 15'd49, 15'd98, 15'd196, 15'd392, 15'd784, 15'd1568, 15'd3136, 15'd6272,
      15'd12544},
    '{15'd25, 15'd51, 15'd103, 15'd207, 15'd415, 15'd830, 15'd1661, 15'd3322, 15'd6644,
      15'd13289},
    '{15'd27, 15'd55, 15'd110, 15'd220, 15'd440, 15'd880, 15'd1760, 15'd3520, 15'd7040,
      15'd14080},
    '{15'd29, 15'd58, 15'd116, 15'd233, 15'd466, 15'd932, 15'd1864, 15'd3729, 15'd7458,
      15'd14917},
    '{15'd30, 15'd61, 15'd123, 15'd246, 15'd493, 15'd987, 15'd1975, 15'd3951, 15'd7902,
      15'd15804},
    '{15'd32, 15'd65, 15'd130, 15'd261, 15'd523, 15'd1046, 15'd2093, 15'd4186, 15'd8372,
      15'd16744}
  };

  function automatic logic [FREQ_W-1:0] note_freq(input logic [3:0] p, input logic [3:0] o);
    logic [3:0] row;
    row = p - 4'd1;
    if (p >= 4'd1 && p <= 4'd13 && o <= 4'd9) begin
      return FREQ_TAB[row][o];
    end
    return '0;
  endfunction

endpackage

// ===== rtl/rtp_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module rtp_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rtp_pkg::WHOLE_W-1:0]  dividend,
  input  logic [rtp_pkg::NUM_W-1:0]    divisor,
  output rtp_pkg::div_stat_t           stat,
  output logic [rtp_pkg::WHOLE_W-1:0]  quotient
);
  import rtp_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [WHOLE_W-1:0] q;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsr;
  logic [NUM_W:0]   trial;

  assign trial = {rem, q[WHOLE_W-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      q <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= NUM_W'(trial - {1'b0, dsr});
        q <= {q[WHOLE_W-2:0], 1'b1};
      end else begin
        rem <= trial[NUM_W-1:0];
        q <= {q[WHOLE_W-2:0], 1'b0};
      end
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient = q;

endmodule

// ===== rtl/ringtone_text_note_parser.sv =====
// Ringtone text parser: one character per transfer in, one note per transfer out.
// A character needing no division is stepped before in_ready rises again; a letter or
// the header end adds a divider pass (two passes when one character
// ends the header and starts the first note), so the divider sets the sustained rate.
// A song end result follows its zero byte, or a divider pass if a length is pending.
// Synchronous reset restores the defaults and drops out_valid.
module ringtone_text_note_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   ch,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         note_valid,
  output logic                         is_rest,
  output logic [rtp_pkg::FREQ_W-1:0]   frequency_hz,
  output logic [rtp_pkg::TIME_W-1:0]   duration_ms,
  output logic                         song_end
);
  import rtp_pkg::*;
  `include "ringtone_text_note_parser_defines.svh"

  localparam logic [4:0] PH_NAME = 5'd0;
  localparam logic [4:0] PH_HD = 5'd1;
  localparam logic [4:0] PH_DSKIP = 5'd2;
  localparam logic [4:0] PH_DNUM = 5'd3;
  localparam logic [4:0] PH_HO = 5'd4;
  localparam logic [4:0] PH_OSKIP = 5'd5;
  localparam logic [4:0] PH_ODIG = 5'd6;
  localparam logic [4:0] PH_OCOMMA = 5'd7;
  localparam logic [4:0] PH_HB = 5'd8;
  localparam logic [4:0] PH_BSKIP = 5'd9;
  localparam logic [4:0] PH_BNUM = 5'd10;
  localparam logic [4:0] PH_NSTART = 5'd11;
  localparam logic [4:0] PH_NLEN = 5'd12;
  localparam logic [4:0] PH_LETTER = 5'd13;
  localparam logic [4:0] PH_SHARP = 5'd14;
  localparam logic [4:0] PH_DOT1 = 5'd15;
  localparam logic [4:0] PH_OCT = 5'd16;
  localparam logic [4:0] PH_DOT2 = 5'd17;

  localparam logic [1:0] CTL_IDLE = 2'd0;
  localparam logic [1:0] CTL_STEP = 2'd1;
  localparam logic [1:0] CTL_DIVW = 2'd2;

  localparam logic [NUM_W-1:0] DEFAULT_BPM = NUM_W'(63);
  localparam logic [WHOLE_W-1:0] MINUTE_MS = WHOLE_W'(60000);

  logic [1:0]         ctl;
  logic [7:0]         chr;
  logic [4:0]         phase;
  logic [NUM_W-1:0]   acc;
  logic [NUM_W-1:0]   dlen;
  logic [3:0]         doct;
  logic [WHOLE_W-1:0] whole;
  logic [3:0]         pidx;
  logic [3:0]         noct;
  logic [TIME_W-1:0]  ntime;
  logic               div_note;
  logic               end_pend;
  logic               div_start;
  logic [WHOLE_W-1:0] div_a;
  logic [NUM_W-1:0]   div_b;
  logic [WHOLE_W-1:0] div_q;
  div_stat_t          div_stat;
  logic               is_dig;
  logic [3:0]         dig;
  logic [NUM_W-1:0]   acc_next;
  logic [16:0]        acc_wide;
  logic [NUM_W-1:0]   note_div;
  logic [TIME_W-1:0]  dotted;

  rtp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_stat),
    .quotient (div_q)
  );

  function automatic logic [3:0] letter_pitch(input logic [7:0] c);
    case (c)
      "c": return 4'd1;
      "d": return 4'd3;
      "e": return 4'd5;
      "f": return 4'd6;
      "g": return 4'd8;
      "a": return 4'd10;
      "b": return 4'd12;
      default: return 4'd0;
    endcase
  endfunction

  assign is_dig = chr >= "0" && chr <= "9";
  assign dig = chr[3:0];
  assign acc_wide = {3'b0, acc} * 17'd10 + {13'b0, dig};
  assign acc_next = (acc_wide > 17'(NUMBER_LIMIT)) ? NUM_W'(NUMBER_LIMIT) : acc_wide[NUM_W-1:0];
  assign note_div = (acc != '0) ? acc : dlen;
  assign dotted = ntime + {1'b0, ntime[TIME_W-1:1]};
  assign in_ready = ctl == CTL_IDLE && !out_valid;

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
    if (rst) begin
      ctl <= CTL_IDLE;
      out_valid <= 1'b0;
      phase <= PH_NAME;
      acc <= '0;
      dlen <= NUM_W'(4);
      doct <= 4'd5;
      whole <= '0;
      pidx <= '0;
      noct <= '0;
      ntime <= '0;
      div_note <= 1'b0;
      end_pend <= 1'b0;
    end else begin
      case (ctl)
        CTL_IDLE: begin
          if (in_valid && in_ready) begin
            chr <= ch;
            ctl <= CTL_STEP;
          end
        end
        CTL_STEP: begin
          ctl <= CTL_IDLE;
          if (chr == 8'd0) begin
            if (phase == PH_NLEN) begin
              div_a <= whole;
              div_b <= note_div;
              div_note <= 1'b1;
              div_start <= 1'b1;
              end_pend <= 1'b1;
              pidx <= '0;
              noct <= doct;
              ctl <= CTL_DIVW;
            end else begin
              out_valid <= 1'b1;
              song_end <= 1'b1;
              note_valid <= phase >= PH_LETTER && phase <= PH_DOT2;
              if (phase >= PH_LETTER && phase <= PH_DOT2) begin
                is_rest <= pidx == '0;
                frequency_hz <= note_freq(pidx, noct);
                duration_ms <= ntime;
              end else begin
                is_rest <= 1'b0;
                frequency_hz <= '0;
                duration_ms <= '0;
              end
              phase <= PH_NAME;
              acc <= '0;
              dlen <= NUM_W'(4);
              doct <= 4'd5;
              whole <= '0;
              pidx <= '0;
              noct <= '0;
              ntime <= '0;
            end
          end else begin
            case (phase)
              PH_NAME: begin
                if (chr == ":") phase <= PH_HD;
              end
              PH_HD: begin
                if (chr == "d") begin
                  phase <= PH_DSKIP;
                end else begin
                  phase <= PH_HO;
                  ctl <= CTL_STEP;
                end
              end
              PH_DSKIP: begin
                acc <= '0;
                phase <= PH_DNUM;
              end
              PH_DNUM: begin
                if (is_dig) begin
                  acc <= acc_next;
                end else begin
                  if (acc != '0) dlen <= acc;
                  phase <= PH_HO;
                  if (chr != ",") ctl <= CTL_STEP;
                end
              end
              PH_HO: begin
                if (chr == "o") begin
                  phase <= PH_OSKIP;
                end else begin
                  phase <= PH_HB;
                  ctl <= CTL_STEP;
                end
              end
              PH_OSKIP: phase <= PH_ODIG;
              PH_ODIG: begin
                if (chr >= "3" && chr <= "7") doct <= dig;
                phase <= PH_OCOMMA;
              end
              PH_OCOMMA: begin
                phase <= PH_HB;
                if (chr != ",") ctl <= CTL_STEP;
              end
              PH_HB: begin
                if (chr == "b") begin
                  phase <= PH_BSKIP;
                end else begin
                  div_a <= MINUTE_MS;
                  div_b <= DEFAULT_BPM;
                  div_note <= 1'b0;
                  div_start <= 1'b1;
                  ctl <= CTL_DIVW;
                end
              end
              PH_BSKIP: begin
                acc <= '0;
                phase <= PH_BNUM;
              end
              PH_BNUM: begin
                if (is_dig) begin
                  acc <= acc_next;
                end else begin
                  div_a <= MINUTE_MS;
                  div_b <= (acc != '0) ? acc : DEFAULT_BPM;
                  div_note <= 1'b0;
                  div_start <= 1'b1;
                  ctl <= CTL_DIVW;
                end
              end
              PH_NSTART: begin
                if (is_dig) begin
                  acc <= {10'b0, dig};
                  phase <= PH_NLEN;
                end else begin
                  acc <= '0;
                  div_a <= whole;
                  div_b <= dlen;
                  div_note <= 1'b1;
                  div_start <= 1'b1;
                  pidx <= letter_pitch(chr);
                  noct <= doct;
                  ctl <= CTL_DIVW;
                end
              end
              PH_NLEN: begin
                if (is_dig) begin
                  acc <= acc_next;
                end else begin
                  div_a <= whole;
                  div_b <= note_div;
                  div_note <= 1'b1;
                  div_start <= 1'b1;
                  pidx <= letter_pitch(chr);
                  noct <= doct;
                  ctl <= CTL_DIVW;
                end
              end
              PH_LETTER: begin
                phase <= PH_SHARP;
                if (chr == "#") pidx <= pidx + 4'd1;
                else ctl <= CTL_STEP;
              end
              PH_SHARP: begin
                phase <= PH_DOT1;
                if (chr == ".") ntime <= dotted;
                else ctl <= CTL_STEP;
              end
              PH_DOT1: begin
                phase <= PH_OCT;
                if (is_dig) noct <= dig;
                else ctl <= CTL_STEP;
              end
              PH_OCT: begin
                phase <= PH_DOT2;
                if (chr == ".") ntime <= dotted;
                else ctl <= CTL_STEP;
              end
              PH_DOT2: begin
                out_valid <= 1'b1;
                note_valid <= 1'b1;
                song_end <= 1'b0;
                is_rest <= pidx == '0;
                frequency_hz <= note_freq(pidx, noct);
                duration_ms <= ntime;
                phase <= PH_NSTART;
                if (chr != ",") ctl <= CTL_STEP;
              end
              default: phase <= PH_NAME;
            endcase
          end
        end
        CTL_DIVW: begin
          if (div_stat.done) begin
            ctl <= CTL_IDLE;
            if (div_note) begin
              ntime <= TIME_W'(div_q);
              phase <= PH_LETTER;
              if (end_pend) begin
                end_pend <= 1'b0;
                out_valid <= 1'b1;
                note_valid <= 1'b1;
                song_end <= 1'b1;
                is_rest <= 1'b1;
                frequency_hz <= '0;
                duration_ms <= TIME_W'(div_q);
                phase <= PH_NAME;
                acc <= '0;
                dlen <= NUM_W'(4);
                doct <= 4'd5;
                whole <= '0;
                pidx <= '0;
                noct <= '0;
                ntime <= '0;
              end
            end else begin
              whole <= {div_q[WHOLE_W-3:0], 2'b00};
              phase <= PH_NSTART;
              if (chr != ":") ctl <= CTL_STEP;
            end
          end
        end
        default: ctl <= CTL_IDLE;
      endcase
    end
  end

  `RTP_ASSERT_SAME(a_busy_not_ready, div_stat.busy, !in_ready)
  `RTP_ASSERT_SAME(a_rest_silent, out_valid && note_valid && is_rest, frequency_hz == '0)
  `RTP_ASSERT_SAME(a_end_only_empty, out_valid && !note_valid,
                   song_end && !is_rest && frequency_hz == '0 && duration_ms == '0)
  `RTP_ASSERT_NEXT(a_start_waits, div_start, ctl == CTL_DIVW)

endmodule
